// File: src/rac_pkg.sv
`default_nettype none
package rac_pkg;

  typedef struct packed {
    logic        [23:0] voltage_scale;
    logic        [23:0] current_scale;
    logic signed [31:0] temp_cubic_coeff;
    logic signed [31:0] temp_square_coeff;
    logic signed [31:0] temp_linear_coeff;
    logic signed [31:0] temp_const_term;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_VOLTAGE_SCALE = 3'd0,
    REG_CURRENT_SCALE = 3'd1,
    REG_TEMP_CUBIC    = 3'd2,
    REG_TEMP_SQUARE   = 3'd3,
    REG_TEMP_LINEAR   = 3'd4,
    REG_TEMP_OFFSET   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  // one multiply per step; the last step only finishes the polynomial
  typedef enum logic [2:0] {
    ST_VOUT,
    ST_VBUS,
    ST_LOAD,
    ST_BATT,
    ST_CUBE,
    ST_SQR,
    ST_LIN,
    ST_OFFS
  } step_t;

endpackage
`default_nettype wire

// File: src/rac_fifo.sv
`default_nettype none
module rac_fifo #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] head
);
  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r;

  assign full      = (cnt_r == CNTW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  function automatic logic [PTRW-1:0] bump(input logic [PTRW-1:0] p);
    if (p == PTRW'(DEPTH - 1)) return '0;
    return p + PTRW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CNTW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end
endmodule
`default_nettype wire

// File: src/rac_front.sv
`default_nettype none
module rac_front #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ADC_BITS-1:0]   in_vout_sample,
  input  wire logic [ADC_BITS-1:0]   in_vbus_sample,
  input  wire logic [ADC_BITS-1:0]   in_load_current_sample,
  input  wire logic [ADC_BITS-1:0]   in_battery_current_sample,
  input  wire logic [ADC_BITS-1:0]   in_thermistor_sample,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [5*ADC_BITS-1:0]      q_data
);
  logic [ADC_BITS-1:0] prev_load_r, prev_batt_r;
  logic [ADC_BITS-1:0] load_damped, batt_damped;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // half old, half new; the two halves always sum within ADC_BITS
  assign load_damped = (in_load_current_sample >> 1) + (prev_load_r >> 1);
  assign batt_damped = (in_battery_current_sample >> 1) + (prev_batt_r >> 1);

  assign q_data = {in_vout_sample, in_vbus_sample, in_thermistor_sample,
                   load_damped, batt_damped};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_load_r <= '0;
      prev_batt_r <= '0;
    end else if (q_push) begin
      prev_load_r <= load_damped;
      prev_batt_r <= batt_damped;
    end
  end
endmodule
`default_nettype wire

// File: src/rac_div.sv
`default_nettype none
// floor(dividend / L) as dividend * ceil(2^SH / L) >> SH, one 16-bit slice
// of the dividend per cycle, most significant slice first
module rac_div #(
  parameter int DW = 42,
  parameter int MW = 52,
  parameter int SH = 52
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [MW-1:0] recip,
  output logic               busy,
  output logic               done,
  output logic [31:0]        quotient
);
  localparam int CW  = 16;
  localparam int NCH = (DW + CW - 1) / CW;
  localparam int NW  = NCH * CW;
  localparam int AW  = NW + MW;
  localparam int IW  = $clog2(NCH + 1);

  logic [NW-1:0]    num_r;
  logic [MW-1:0]    recip_r;
  logic [AW-1:0]    acc_r;
  logic [IW-1:0]    iter_r;
  logic             busy_r, done_r;
  logic [CW+MW-1:0] part;

  assign part     = num_r[NW-1 -: CW] * recip_r;
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = acc_r[SH +: 32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + IW'(1);
        if (iter_r == IW'(NCH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r   <= NW'(dividend);
      recip_r <= recip;
      acc_r   <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[AW-CW-1:0], {CW{1'b0}}} + AW'(part);
      num_r <= {num_r[NW-CW-1:0], {CW{1'b0}}};
    end
  end
endmodule
`default_nettype wire

// File: src/rac_back.sv
`default_nettype none
module rac_back
  import rac_pkg::*;
#(
  parameter int ADC_BITS          = 10,
  parameter int VBUS_BLOCK_LEN    = 1001,
  parameter int CURRENT_BLOCK_LEN = 201
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic                  q_valid,
  input  wire logic [5*ADC_BITS-1:0] q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_vout_value,
  output logic [31:0]                out_vbus_value,
  output logic [31:0]                out_load_current_value,
  output logic [31:0]                out_battery_current_value,
  output logic signed [31:0]         out_temperature_value,
  output logic [31:0]                out_vbus_average,
  output logic [31:0]                out_load_current_average,
  output logic [31:0]                out_battery_current_average
);
  localparam int A   = ADC_BITS;
  localparam int PW  = 49 + A;
  localparam int VCW = $clog2(VBUS_BLOCK_LEN + 1);
  localparam int CCW = $clog2(CURRENT_BLOCK_LEN + 1);
  localparam int VSW = 32 + VCW;
  localparam int CSW = 32 + CCW;
  localparam int DW  = (VSW > CSW) ? VSW : CSW;
  localparam int LW  = (VCW > CCW) ? VCW : CCW;
  // 2^SH exceeds every sum times the rounding error of the reciprocal
  localparam int SH  = DW + LW;
  localparam int MW  = SH;
  localparam longint VBUS_RECIP =
    ((longint'(1) << SH) + longint'(VBUS_BLOCK_LEN) - 1) / longint'(VBUS_BLOCK_LEN);
  localparam longint CUR_RECIP =
    ((longint'(1) << SH) + longint'(CURRENT_BLOCK_LEN) - 1) / longint'(CURRENT_BLOCK_LEN);
  localparam logic [1:0] CH_VBUS = 2'd0;
  localparam logic [1:0] CH_LOAD = 2'd1;
  localparam logic [1:0] CH_BATT = 2'd2;

  bk_state_t state_r, state_nxt;
  step_t     step_r;

  logic [5*A-1:0] ent_r;
  logic [A-1:0]   e_vout, e_vbus, e_therm, e_dl, e_db;
  assign {e_vout, e_vbus, e_therm, e_dl, e_db} = ent_r;

  logic signed [47:0]   opa;
  logic signed [A:0]    opb;
  logic signed [PW-1:0] mul_full, prod_r, a_full, b_full, t_full;
  logic [31:0]          vout_v_r, vbus_v_r, load_v_r, batt_v_r;
  logic signed [31:0]   temp_r, temp_sat;

  logic [VCW-1:0] vbus_cnt_r;
  logic [CCW-1:0] load_cnt_r, batt_cnt_r;
  logic [VSW-1:0] vbus_sum_r, vbus_sum_add;
  logic [CSW-1:0] load_sum_r, batt_sum_r, load_sum_add, batt_sum_add;
  logic [31:0]    held_vbus_r, held_load_r, held_batt_r;
  logic [2:0]     pend_r;
  logic [1:0]     div_ch_r, div_sel;

  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dividend;
  logic [MW-1:0] div_recip;
  logic [31:0]   div_quo;

  logic out_valid_r, out_load;

  function automatic logic [31:0] sat_u(input logic signed [PW-1:0] p);
    if (|p[PW-1:36]) return 32'hFFFF_FFFF;
    return p[35:4];
  endfunction

  assign a_full   = (prod_r >>> 10) + PW'(cfg.temp_square_coeff);
  assign b_full   = (prod_r >>> 10) + PW'(cfg.temp_linear_coeff);
  assign t_full   = (prod_r >>> 4) + PW'(cfg.temp_const_term);
  assign mul_full = opa * opb;

  always_comb begin
    if (t_full[PW-1] && !(&t_full[PW-2:31]))     temp_sat = 32'sh8000_0000;
    else if (!t_full[PW-1] && (|t_full[PW-2:31])) temp_sat = 32'sh7FFF_FFFF;
    else                                          temp_sat = t_full[31:0];
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (step_r)
      ST_VOUT: begin opa = {24'd0, cfg.voltage_scale}; opb = {1'b0, e_vout};  end
      ST_VBUS: begin opa = {24'd0, cfg.voltage_scale}; opb = {1'b0, e_vbus};  end
      ST_LOAD: begin opa = {24'd0, cfg.current_scale}; opb = {1'b0, e_dl};    end
      ST_BATT: begin opa = {24'd0, cfg.current_scale}; opb = {1'b0, e_db};    end
      ST_CUBE: begin opa = 48'(cfg.temp_cubic_coeff);  opb = {1'b0, e_therm}; end
      ST_SQR:  begin opa = a_full[47:0];               opb = {1'b0, e_therm}; end
      ST_LIN:  begin opa = b_full[47:0];               opb = {1'b0, e_therm}; end
      default: begin opa = '0;                         opb = '0;              end
    endcase
  end

  assign vbus_sum_add = vbus_sum_r + VSW'(vbus_v_r);
  assign load_sum_add = load_sum_r + CSW'(load_v_r);
  assign batt_sum_add = batt_sum_r + CSW'(batt_v_r);

  always_comb begin
    if (pend_r[CH_VBUS])      div_sel = CH_VBUS;
    else if (pend_r[CH_LOAD]) div_sel = CH_LOAD;
    else                      div_sel = CH_BATT;
  end

  assign div_start = (state_r == BK_DIV) && !div_busy && !div_done && (|pend_r);

  always_comb begin
    case (div_sel)
      CH_VBUS: begin
        div_dividend = DW'(vbus_sum_r);
        div_recip    = MW'(VBUS_RECIP);
      end
      CH_LOAD: begin
        div_dividend = DW'(load_sum_r);
        div_recip    = MW'(CUR_RECIP);
      end
      default: begin
        div_dividend = DW'(batt_sum_r);
        div_recip    = MW'(CUR_RECIP);
      end
    endcase
  end

  rac_div #(.DW(DW), .MW(MW), .SH(SH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .recip    (div_recip),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_MUL;
      BK_MUL:  if (step_r == ST_OFFS) state_nxt = BK_DIV;
      BK_DIV:  if (!div_busy && !div_done && pend_r == 3'd0) state_nxt = BK_OUT;
      BK_OUT:  if (!out_valid_r || !out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == BK_IDLE) && q_valid;
    out_load = (state_r == BK_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= ST_VOUT;
      out_valid_r <= 1'b0;
      vbus_cnt_r  <= '0;
      load_cnt_r  <= '0;
      batt_cnt_r  <= '0;
      vbus_sum_r  <= '0;
      load_sum_r  <= '0;
      batt_sum_r  <= '0;
      held_vbus_r <= '0;
      held_load_r <= '0;
      held_batt_r <= '0;
      pend_r      <= '0;
      div_ch_r    <= CH_VBUS;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_MUL) step_r <= step_t'(step_r + 3'd1);
      else                   step_r <= ST_VOUT;

      if (out_load)                  out_valid_r <= 1'b1;
      else if (!out_stall)           out_valid_r <= 1'b0;

      if (state_r == BK_MUL && step_r == ST_OFFS) begin
        if (vbus_cnt_r == VCW'(VBUS_BLOCK_LEN - 1)) begin
          vbus_cnt_r      <= '0;
          pend_r[CH_VBUS] <= 1'b1;
        end else begin
          vbus_cnt_r <= vbus_cnt_r + VCW'(1);
        end
        vbus_sum_r <= vbus_sum_add;
        if (load_cnt_r == CCW'(CURRENT_BLOCK_LEN - 1)) begin
          load_cnt_r      <= '0;
          pend_r[CH_LOAD] <= 1'b1;
        end else begin
          load_cnt_r <= load_cnt_r + CCW'(1);
        end
        load_sum_r <= load_sum_add;
        if (batt_cnt_r == CCW'(CURRENT_BLOCK_LEN - 1)) begin
          batt_cnt_r      <= '0;
          pend_r[CH_BATT] <= 1'b1;
        end else begin
          batt_cnt_r <= batt_cnt_r + CCW'(1);
        end
        batt_sum_r <= batt_sum_add;
      end

      // a finished block hands its sum to the divider and restarts from zero
      if (div_start) begin
        div_ch_r <= div_sel;
        case (div_sel)
          CH_VBUS: vbus_sum_r <= '0;
          CH_LOAD: load_sum_r <= '0;
          default: batt_sum_r <= '0;
        endcase
      end

      if (div_done) begin
        pend_r[div_ch_r] <= 1'b0;
        case (div_ch_r)
          CH_VBUS: held_vbus_r <= div_quo;
          CH_LOAD: held_load_r <= div_quo;
          default: held_batt_r <= div_quo;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) ent_r <= q_data;
    if (state_r == BK_MUL) begin
      prod_r <= mul_full;
      case (step_r)
        ST_VBUS: vout_v_r <= sat_u(prod_r);
        ST_LOAD: vbus_v_r <= sat_u(prod_r);
        ST_BATT: load_v_r <= sat_u(prod_r);
        ST_CUBE: batt_v_r <= sat_u(prod_r);
        ST_OFFS: temp_r   <= temp_sat;
        default: ;
      endcase
    end
    if (out_load) begin
      out_vout_value              <= vout_v_r;
      out_vbus_value              <= vbus_v_r;
      out_load_current_value      <= load_v_r;
      out_battery_current_value   <= batt_v_r;
      out_temperature_value       <= temp_r;
      out_vbus_average            <= held_vbus_r;
      out_load_current_average    <= held_load_r;
      out_battery_current_average <= held_batt_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_start_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> state_r == BK_DIV) else $error("divider started outside divide phase");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == BK_DIV) else $error("divide finished outside divide phase");
  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE) else $error("queue popped while busy");
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MUL && step_r == ST_OFFS) |=> state_r == BK_DIV)
    else $error("sequencer skipped the divide phase");
`endif
endmodule
`default_nettype wire

// File: src/rectifier_adc_conditioning_core.sv
`default_nettype none
// Conditions one set of five ADC readings per item into Q16.16 voltages,
// damped currents, a cubic-fit temperature and held block averages of bus
// voltage and both currents. Items are queued two deep at the input; a
// sequencer then runs them one at a time through a single shared multiplier
// in eight steps. Each item is taken from the queue, run through the eight
// steps, checked for finished blocks and loaded into the output register;
// a new item is taken only once the last one is loaded, and not while the
// output is stalled. On the item that closes an averaging block, each
// refreshed average is computed by the divider (its sum is multiplied by a
// constant reciprocal of the block length, sixteen bits of sum per cycle),
// one after another, before that item's result is shown. Configuration is
// a simple register write port, always ready.
module rectifier_adc_conditioning_core
  import rac_pkg::*;
#(
  parameter int ADC_BITS          = 10,
  parameter int VBUS_BLOCK_LEN    = 1001,
  parameter int CURRENT_BLOCK_LEN = 201
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ADC_BITS-1:0] in_vout_sample,
  input  wire logic [ADC_BITS-1:0] in_vbus_sample,
  input  wire logic [ADC_BITS-1:0] in_load_current_sample,
  input  wire logic [ADC_BITS-1:0] in_battery_current_sample,
  input  wire logic [ADC_BITS-1:0] in_thermistor_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [31:0]              out_vout_value,
  output logic [31:0]              out_vbus_value,
  output logic [31:0]              out_load_current_value,
  output logic [31:0]              out_battery_current_value,
  output logic signed [31:0]       out_temperature_value,
  output logic [31:0]              out_vbus_average,
  output logic [31:0]              out_load_current_average,
  output logic [31:0]              out_battery_current_average
);
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VOLTAGE_SCALE: cfg_r.voltage_scale     <= cfg_data[23:0];
        REG_CURRENT_SCALE: cfg_r.current_scale     <= cfg_data[23:0];
        REG_TEMP_CUBIC:    cfg_r.temp_cubic_coeff  <= cfg_data;
        REG_TEMP_SQUARE:   cfg_r.temp_square_coeff <= cfg_data;
        REG_TEMP_LINEAR:   cfg_r.temp_linear_coeff <= cfg_data;
        REG_TEMP_OFFSET:   cfg_r.temp_const_term   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                  q_full, q_push, q_valid, q_pop;
  logic [5*ADC_BITS-1:0] q_in, q_head;

  rac_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_vout_sample            (in_vout_sample),
    .in_vbus_sample            (in_vbus_sample),
    .in_load_current_sample    (in_load_current_sample),
    .in_battery_current_sample (in_battery_current_sample),
    .in_thermistor_sample      (in_thermistor_sample),
    .q_full                    (q_full),
    .q_push                    (q_push),
    .q_data                    (q_in)
  );

  rac_fifo #(.WIDTH(5*ADC_BITS), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  rac_back #(
    .ADC_BITS          (ADC_BITS),
    .VBUS_BLOCK_LEN    (VBUS_BLOCK_LEN),
    .CURRENT_BLOCK_LEN (CURRENT_BLOCK_LEN)
  ) u_back (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .cfg                         (cfg_r),
    .q_valid                     (q_valid),
    .q_data                      (q_head),
    .q_pop                       (q_pop),
    .out_valid                   (out_valid),
    .out_stall                   (out_stall),
    .out_vout_value              (out_vout_value),
    .out_vbus_value              (out_vbus_value),
    .out_load_current_value      (out_load_current_value),
    .out_battery_current_value   (out_battery_current_value),
    .out_temperature_value       (out_temperature_value),
    .out_vbus_average            (out_vbus_average),
    .out_load_current_average    (out_load_current_average),
    .out_battery_current_average (out_battery_current_average)
  );
endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench
  import rac_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0] vout;
    logic [9:0] vbus;
    logic [9:0] iload;
    logic [9:0] ibatt;
    logic [9:0] therm;
  } sample_set_t;

  typedef struct {
    logic [31:0]        vout;
    logic [31:0]        vbus;
    logic [31:0]        iload;
    logic [31:0]        ibatt;
    logic signed [31:0] temp;
    logic [31:0]        vbus_avg;
    logic [31:0]        load_avg;
    logic [31:0]        batt_avg;
  } reading_t;

  localparam int VBUS_LEN = 1001;
  localparam int CUR_LEN  = 201;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] in_vout_sample = '0;
  logic [9:0] in_vbus_sample = '0;
  logic [9:0] in_load_current_sample = '0;
  logic [9:0] in_battery_current_sample = '0;
  logic [9:0] in_thermistor_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_vout_value, out_vbus_value, out_load_current_value;
  logic [31:0] out_battery_current_value;
  logic signed [31:0] out_temperature_value;
  logic [31:0] out_vbus_average, out_load_current_average, out_battery_current_average;

  rectifier_adc_conditioning_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vout_sample(in_vout_sample), .in_vbus_sample(in_vbus_sample),
    .in_load_current_sample(in_load_current_sample),
    .in_battery_current_sample(in_battery_current_sample),
    .in_thermistor_sample(in_thermistor_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vout_value(out_vout_value), .out_vbus_value(out_vbus_value),
    .out_load_current_value(out_load_current_value),
    .out_battery_current_value(out_battery_current_value),
    .out_temperature_value(out_temperature_value),
    .out_vbus_average(out_vbus_average),
    .out_load_current_average(out_load_current_average),
    .out_battery_current_average(out_battery_current_average)
  );

  // calibration copy
  logic [23:0] vscale_copy, cur_gain;
  longint c3, c2, c1, c0;
  // conditioning state copy
  logic [9:0] last_load, last_batt;
  int unsigned vbus_cnt, load_cnt, batt_cnt;
  longint unsigned vbus_acc, load_acc, batt_acc;
  logic [31:0] vbus_hold, load_hold, batt_hold;

  sample_set_t pending_sets[$];
  reading_t expected_readings[$];
  int fails = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] scale_reading(logic [9:0] x, logic [23:0] g);
    longint unsigned p;
    p = (longint'(x) * longint'(g)) >> 4;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic signed [31:0] thermistor_temp(logic [9:0] raw);
    longint x, a, b, t;
    x = longint'(raw);
    a = ((c3 * x) >>> 10) + c2;
    b = ((a * x) >>> 10) + c1;
    t = ((b * x) >>> 4) + c0;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  task automatic block_average(inout longint unsigned acc, inout int unsigned cnt,
                               input int unsigned len, inout logic [31:0] hold,
                               input logic [31:0] v);
    acc += v;
    cnt++;
    if (cnt >= len) begin
      hold = 32'(acc / cnt);
      acc = 0;
      cnt = 0;
    end
  endtask

  task automatic condition_set(input sample_set_t s);
    reading_t r;
    logic [9:0] dl, db;
    dl = (s.iload >> 1) + (last_load >> 1);
    db = (s.ibatt >> 1) + (last_batt >> 1);
    last_load = dl;
    last_batt = db;
    r.vout = scale_reading(s.vout, vscale_copy);
    r.vbus = scale_reading(s.vbus, vscale_copy);
    r.iload = scale_reading(dl, cur_gain);
    r.ibatt = scale_reading(db, cur_gain);
    r.temp = thermistor_temp(s.therm);
    block_average(vbus_acc, vbus_cnt, VBUS_LEN, vbus_hold, r.vbus);
    block_average(load_acc, load_cnt, CUR_LEN, load_hold, r.iload);
    block_average(batt_acc, batt_cnt, CUR_LEN, batt_hold, r.ibatt);
    r.vbus_avg = vbus_hold;
    r.load_avg = load_hold;
    r.batt_avg = batt_hold;
    expected_readings.push_back(r);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h want %h at %0t", field, got, want, $realtime);
    fails++;
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    sample_set_t s;
    logic busy;
    if (rst_n) begin
      busy = 1'b0;
      if (in_valid && !in_stall) begin
        s.vout = in_vout_sample;
        s.vbus = in_vbus_sample;
        s.iload = in_load_current_sample;
        s.ibatt = in_battery_current_sample;
        s.therm = in_thermistor_sample;
        condition_set(s);
        void'(pending_sets.pop_front());
      end else if (in_valid) begin
        busy = 1'b1;
      end
      if (!busy) begin
        if (gap_left > 0 || pending_sets.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_vout_sample <= pending_sets[0].vout;
          in_vbus_sample <= pending_sets[0].vbus;
          in_load_current_sample <= pending_sets[0].iload;
          in_battery_current_sample <= pending_sets[0].ibatt;
          in_thermistor_sample <= pending_sets[0].therm;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    reading_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("unexpected item at %0t", $realtime);
          fails++;
        end else begin
          w = expected_readings.pop_front();
          if (out_vout_value !== w.vout) report_mismatch("vout", out_vout_value, w.vout);
          if (out_vbus_value !== w.vbus) report_mismatch("vbus", out_vbus_value, w.vbus);
          if (out_load_current_value !== w.iload)
            report_mismatch("load_current", out_load_current_value, w.iload);
          if (out_battery_current_value !== w.ibatt)
            report_mismatch("battery_current", out_battery_current_value, w.ibatt);
          if (out_temperature_value !== w.temp)
            report_mismatch("temperature", out_temperature_value, w.temp);
          if (out_vbus_average !== w.vbus_avg)
            report_mismatch("vbus_average", out_vbus_average, w.vbus_avg);
          if (out_load_current_average !== w.load_avg)
            report_mismatch("load_average", out_load_current_average, w.load_avg);
          if (out_battery_current_average !== w.batt_avg)
            report_mismatch("battery_average", out_battery_current_average, w.batt_avg);
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_VOLTAGE_SCALE: vscale_copy = val[23:0];
      REG_CURRENT_SCALE: cur_gain = val[23:0];
      REG_TEMP_CUBIC:    c3 = longint'($signed(val));
      REG_TEMP_SQUARE:   c2 = longint'($signed(val));
      REG_TEMP_LINEAR:   c1 = longint'($signed(val));
      default:           c0 = longint'($signed(val));
    endcase
  endtask

  function automatic logic [9:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic add_set(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                         logic [9:0] d, logic [9:0] e);
    sample_set_t s;
    s.vout = a; s.vbus = b; s.iload = c; s.ibatt = d; s.therm = e;
    pending_sets.push_back(s);
  endtask

  task automatic drain();
    while (pending_sets.size() != 0 || expected_readings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    logic [31:0] cv[6];
    vscale_copy = '0; cur_gain = '0; c3 = 0; c2 = 0; c1 = 0; c0 = 0;
    last_load = '0; last_batt = '0;
    vbus_cnt = 0; load_cnt = 0; batt_cnt = 0;
    vbus_acc = 0; load_acc = 0; batt_acc = 0;
    vbus_hold = '0; load_hold = '0; batt_hold = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 11; p++) begin
      if (p == 0) begin
        cv = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      end else if (p == 1) begin
        cv = '{32'hFFFFFF, 32'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      end else if (p == 2) begin
        cv = '{32'h0, 32'h1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
      end else begin
        cv[0] = $urandom_range(0, 24'hFFFFFF);
        cv[1] = $urandom_range(0, 24'hFFFFFF);
        // small polynomial terms keep the temperature mostly in range
        cv[2] = ($urandom_range(0, 1)) ? $urandom : 32'($signed(($urandom_range(0, 2047)) - 1024));
        cv[3] = ($urandom_range(0, 1)) ? $urandom : 32'($signed(($urandom_range(0, 65535)) - 32768));
        cv[4] = $urandom;
        cv[5] = $urandom;
      end
      for (int r = 0; r < 6; r++) write_reg(reg_idx_t'(r), cv[r]);
      cfg_valid <= 1'b0;
      if (p == 1 || p == 2) begin
        add_set(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        add_set(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        add_set(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
        add_set(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
        add_set(10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        add_set(10'd1023, 10'd0, 10'd0, 10'd1023, 10'd512);
        add_set(10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1);
        add_set(10'd1022, 10'd1022, 10'd3, 10'd3, 10'd1022);
        add_set(10'd512, 10'd511, 10'd1023, 10'd1023, 10'd0);
        add_set(10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023);
      end else begin
        for (int i = 0; i < 200; i++)
          add_set(rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw());
      end
      drain();
    end
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
